>>> src/cpct_pkg.sv
// Shared types and constants for the Clarke/Park current transform block.
`default_nettype none

package cpct_pkg;

    // Moving-average length is a power of two: 1 << AVG_LOG2.
    localparam int AVG_LOG2       = 2;
    localparam int AVERAGE_LENGTH = 1 << AVG_LOG2;
    localparam int SLOT_W         = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
    localparam int SUM_W          = 16 + AVG_LOG2;

    // Stream payload widths.
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 32;

    // Fixed-point coefficients.
    localparam logic signed [17:0] RECIP_THREE       = 18'sd43691;  // 2^17 / 3, rounded up
    localparam logic signed [17:0] INV_SQRT3_Q15     = 18'sd18918;
    localparam logic signed [17:0] TWO_INV_SQRT3_Q15 = 18'sd37836;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GAMMA,
        ST_DIFF,
        ST_MUL_BA,
        ST_MUL_BB,
        ST_MUL_D1,
        ST_MUL_D2,
        ST_MUL_Q1,
        ST_MUL_Q2,
        ST_FINISH,
        ST_UPDATE
    } cpct_state_t;

    // Operand pair for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_SUM_RECIP,
        MUL_ALPHA_BETA,
        MUL_DELTA_BETA,
        MUL_COS_ALPHA,
        MUL_SIN_BETA,
        MUL_NSIN_ALPHA,
        MUL_COS_BETA
    } mul_sel_t;

    // Register that takes the truncated product.
    typedef enum logic [1:0] {
        DEST_NONE,
        DEST_BETA,
        DEST_D,
        DEST_Q
    } dest_t;

    typedef struct packed {
        logic     load;       // latch input transaction
        mul_sel_t mul_sel;
        logic     gamma_en;   // form phase differences from common mode
        dest_t    dest;
        logic     dest_add;   // accumulate instead of load
        logic     update;     // moving average update and output load
    } cpct_cmd_t;

    typedef struct packed {
        logic out_busy;       // output register holds an untaken result
    } cpct_status_t;

endpackage

`default_nettype wire

>>> src/cpct_ctrl.sv
// Sequencing state machine for the Clarke/Park current transform.
`default_nettype none

module cpct_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire cpct_pkg::cpct_status_t status,
    output cpct_pkg::cpct_cmd_t        cmd
);
    import cpct_pkg::*;

    cpct_state_t state_reg;
    cpct_state_t state_next;

    // Hold state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through the multiply sequence
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_MUL_GAMMA;
            ST_MUL_GAMMA: state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_MUL_BA;
            ST_MUL_BA:    state_next = ST_MUL_BB;
            ST_MUL_BB:    state_next = ST_MUL_D1;
            ST_MUL_D1:    state_next = ST_MUL_D2;
            ST_MUL_D2:    state_next = ST_MUL_Q1;
            ST_MUL_Q1:    state_next = ST_MUL_Q2;
            ST_MUL_Q2:    state_next = ST_FINISH;
            ST_FINISH:    state_next = ST_UPDATE;
            ST_UPDATE:    if (!status.out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        s_tready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.mul_sel  = MUL_SUM_RECIP;
        cmd.gamma_en = 1'b0;
        cmd.dest     = DEST_NONE;
        cmd.dest_add = 1'b0;
        cmd.update   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL_GAMMA: cmd.mul_sel = MUL_SUM_RECIP;
            ST_DIFF:      cmd.gamma_en = 1'b1;
            ST_MUL_BA:    cmd.mul_sel = MUL_ALPHA_BETA;
            ST_MUL_BB: begin
                cmd.mul_sel = MUL_DELTA_BETA;
                cmd.dest    = DEST_BETA;
            end
            ST_MUL_D1: begin
                cmd.mul_sel  = MUL_COS_ALPHA;
                cmd.dest     = DEST_BETA;
                cmd.dest_add = 1'b1;
            end
            ST_MUL_D2: begin
                cmd.mul_sel = MUL_SIN_BETA;
                cmd.dest    = DEST_D;
            end
            ST_MUL_Q1: begin
                cmd.mul_sel  = MUL_NSIN_ALPHA;
                cmd.dest     = DEST_D;
                cmd.dest_add = 1'b1;
            end
            ST_MUL_Q2: begin
                cmd.mul_sel = MUL_COS_BETA;
                cmd.dest    = DEST_Q;
            end
            ST_FINISH: begin
                cmd.dest     = DEST_Q;
                cmd.dest_add = 1'b1;
            end
            ST_UPDATE:    cmd.update = !status.out_busy;
            default:      s_tready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/cpct_datapath.sv
// Datapath: shared multiplier, Clarke/Park accumulators, moving average, output register.
`default_nettype none

module cpct_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata fields, low bit up: phase_a_sample[11:0], phase_b_sample[23:12],
    // phase_c_sample[35:24], angle_cosine[51:36], angle_sine[67:52], zero pad
    input  wire logic [cpct_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire cpct_pkg::cpct_cmd_t             cmd,
    output cpct_pkg::cpct_status_t               status,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata fields, low bit up: direct_current[14:0], quadrature_current[29:15],
    // zero pad
    output logic [cpct_pkg::M_DATA_W-1:0]        m_tdata
);
    import cpct_pkg::*;

    // Divide a Q15 product by 32768, truncating toward zero.
    function automatic logic signed [17:0] trunc_q15(input logic signed [32:0] p);
        logic signed [32:0] biased;
        biased = p + (p[32] ? 33'sd32767 : 33'sd0);
        return biased[32:15];
    endfunction

    // Latched inputs
    logic        [11:0] a_reg, b_reg;
    logic        [13:0] sum_reg;
    logic signed [15:0] cos_reg, sin_reg;

    // Intermediates
    logic signed [32:0] prod_reg;
    logic signed [12:0] alpha_reg, delta_b_reg;
    logic signed [13:0] beta_reg;
    logic signed [15:0] d_reg, q_reg;

    // Moving-average state
    logic signed [15:0]       d_hist_reg [AVERAGE_LENGTH];
    logic signed [15:0]       q_hist_reg [AVERAGE_LENGTH];
    logic signed [SUM_W-1:0]  d_sum_reg, q_sum_reg;
    logic [SLOT_W-1:0]        slot_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [14:0]       d_out_reg, q_out_reg;

    logic signed [17:0] mul_a;
    logic signed [14:0] mul_b;
    logic signed [32:0] prod_next;
    logic signed [17:0] prod_trunc;
    logic        [11:0] gamma;
    logic signed [SUM_W-1:0] d_sum_next, q_sum_next;
    logic signed [SUM_W-1:0] d_avg, q_avg;
    logic [SLOT_W-1:0]  slot_next;

    // Select multiplier operands
    always_comb begin
        mul_a = RECIP_THREE;
        mul_b = {1'b0, sum_reg};
        unique case (cmd.mul_sel)
            MUL_SUM_RECIP: begin
                mul_a = RECIP_THREE;
                mul_b = {1'b0, sum_reg};
            end
            MUL_ALPHA_BETA: begin
                mul_a = INV_SQRT3_Q15;
                mul_b = {{2{alpha_reg[12]}}, alpha_reg};
            end
            MUL_DELTA_BETA: begin
                mul_a = TWO_INV_SQRT3_Q15;
                mul_b = {{2{delta_b_reg[12]}}, delta_b_reg};
            end
            MUL_COS_ALPHA: begin
                mul_a = {{2{cos_reg[15]}}, cos_reg};
                mul_b = {{2{alpha_reg[12]}}, alpha_reg};
            end
            MUL_SIN_BETA: begin
                mul_a = {{2{sin_reg[15]}}, sin_reg};
                mul_b = {beta_reg[13], beta_reg};
            end
            MUL_NSIN_ALPHA: begin
                mul_a = 18'sd0 - {{2{sin_reg[15]}}, sin_reg};
                mul_b = {{2{alpha_reg[12]}}, alpha_reg};
            end
            MUL_COS_BETA: begin
                mul_a = {{2{cos_reg[15]}}, cos_reg};
                mul_b = {beta_reg[13], beta_reg};
            end
            default: begin
                mul_a = RECIP_THREE;
                mul_b = {1'b0, sum_reg};
            end
        endcase
    end

    assign prod_next  = mul_a * mul_b;
    assign prod_trunc = trunc_q15(prod_reg);
    // Common-mode mean: sum * ceil(2^17 / 3) >> 17 is exact for 14-bit sums
    assign gamma      = prod_reg[28:17];

    // Latch input transaction and register product
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.load) begin
            a_reg   <= s_tdata[11:0];
            b_reg   <= s_tdata[23:12];
            sum_reg <= 14'({2'b00, s_tdata[11:0]} + {2'b00, s_tdata[23:12]}
                           + {2'b00, s_tdata[35:24]});
            cos_reg <= s_tdata[51:36];
            sin_reg <= s_tdata[67:52];
        end
        if (cmd.gamma_en) begin
            alpha_reg   <= $signed({1'b0, gamma}) - $signed({1'b0, a_reg});
            delta_b_reg <= $signed({1'b0, gamma}) - $signed({1'b0, b_reg});
        end
    end

    // Accumulate truncated products into beta, d and q
    always_ff @(posedge aclk) begin
        case (cmd.dest)
            DEST_BETA: beta_reg <= cmd.dest_add ? beta_reg + prod_trunc[13:0]
                                                : prod_trunc[13:0];
            DEST_D:    d_reg <= cmd.dest_add ? d_reg + prod_trunc[15:0]
                                             : prod_trunc[15:0];
            DEST_Q:    q_reg <= cmd.dest_add ? q_reg + prod_trunc[15:0]
                                             : prod_trunc[15:0];
            default:   ;
        endcase
    end

    // Replace the oldest history entry in the running sums
    assign d_sum_next = d_sum_reg - SUM_W'(d_hist_reg[slot_reg]) + SUM_W'(d_reg);
    assign q_sum_next = q_sum_reg - SUM_W'(q_hist_reg[slot_reg]) + SUM_W'(q_reg);
    assign slot_next  = (slot_reg == SLOT_W'(AVERAGE_LENGTH - 1)) ? '0
                                                                  : slot_reg + SLOT_W'(1);

    // Divide by the average length, truncating toward zero
    assign d_avg = (d_sum_next + (d_sum_next[SUM_W-1] ? SUM_W'(AVERAGE_LENGTH - 1) : '0))
                   >>> AVG_LOG2;
    assign q_avg = (q_sum_next + (q_sum_next[SUM_W-1] ? SUM_W'(AVERAGE_LENGTH - 1) : '0))
                   >>> AVG_LOG2;

    // Hold moving-average state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AVERAGE_LENGTH; i++) begin
                d_hist_reg[i] <= '0;
                q_hist_reg[i] <= '0;
            end
            d_sum_reg <= '0;
            q_sum_reg <= '0;
            slot_reg  <= '0;
        end else if (cmd.update) begin
            d_hist_reg[slot_reg] <= d_reg;
            q_hist_reg[slot_reg] <= q_reg;
            d_sum_reg            <= d_sum_next;
            q_sum_reg            <= q_sum_next;
            slot_reg             <= slot_next;
        end
    end

    // Output valid: set on update, drop when the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load output payload
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            d_out_reg <= d_avg[14:0];
            q_out_reg <= q_avg[14:0];
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {2'b00, q_out_reg, d_out_reg};

endmodule

`default_nettype wire

>>> src/clarke_park_current_transform.sv
// One item at a time: a new input transaction is accepted only while the controller is idle.
// Each item runs an accept step plus ten controller steps that share one 18x15 multiplier
// (seven products: common-mode mean, Clarke beta, Park d and q) and a moving-average update.
// The update step waits while a previous result still sits untaken in the output register.
// Reset (aresetn low, synchronous) clears the d/q history rings, running sums, ring position,
// state machine and output valid.
`default_nettype none

module clarke_park_current_transform (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata fields, low bit up: phase_a_sample[11:0], phase_b_sample[23:12],
    // phase_c_sample[35:24], angle_cosine[51:36], angle_sine[67:52], zero pad
    input  wire logic [cpct_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata fields, low bit up: direct_current[14:0], quadrature_current[29:15],
    // zero pad
    output logic [cpct_pkg::M_DATA_W-1:0]        m_tdata
);
    import cpct_pkg::*;

    cpct_cmd_t    cmd;
    cpct_status_t status;

    cpct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cpct_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
